// ----- sv/line_aligned_balanced_stream_splitter_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the line-aligned stream splitter
// Shared concurrent assertion forms, clocked and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LINE_ALIGNED_BALANCED_STREAM_SPLITTER_DEFINES_SVH
`define LINE_ALIGNED_BALANCED_STREAM_SPLITTER_DEFINES_SVH

// same-cycle implication
`define LBSS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LBSS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/lbss_pkg.sv -----
// ---------------------------------------------------------------------------
// lbss_pkg
// Shared constants, codes and control/status types of the stream splitter.
// ---------------------------------------------------------------------------
package lbss_pkg;

    // default widths
    localparam int DEF_BYTE_WIDTH = 48;
    localparam int DEF_LINE_WIDTH = 31;
    localparam int DEF_PART_WIDTH = 12;

    localparam int DEFAULT_PARTS = 100;
    localparam logic [7:0] LINE_FEED = 8'h0A;

    // request types on s_tuser
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_DATA  = 2'd1;
    localparam logic [1:0] REQ_END   = 2'd2;

    // result kinds on m_tuser
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    // configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_TOTAL_BYTES = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_PARTS_COUNT = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic start_stream;
        logic pass_byte;
        logic end_rec;
        logic idle_done;
        logic cut_rec;
        logic done_emit;
        logic open_part;
        logic thr_load;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic part_open;
        logic cut;
        logic slot_free;
        logic open_unlim;
        logic div_done;
        logic div_busy;
    } sts_t;

endpackage

// ----- sv/lbss_div.sv -----
// ---------------------------------------------------------------------------
// lbss_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module lbss_div #(
    parameter int BW = 48,
    parameter int PW = 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [BW-1:0] dividend,
    input  logic [PW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [BW-1:0] quotient,
    output logic          rem_nz
);

    localparam int CNT_W = $clog2(BW + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [BW-1:0]    quo_reg;
    logic [PW-1:0]    rem_reg;
    logic [PW-1:0]    dsr_reg;
    logic [PW:0]      shifted;
    logic [PW:0]      trial;

    // shift in next dividend bit and try the subtract
    assign shifted = {rem_reg, quo_reg[BW-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    // iteration counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(BW);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (cnt_reg != '0) begin
            if (!trial[PW]) begin
                rem_reg <= trial[PW-1:0];
                quo_reg <= {quo_reg[BW-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[PW-1:0];
                quo_reg <= {quo_reg[BW-2:0], 1'b0};
            end
        end
    end

    assign busy     = (cnt_reg != '0);
    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_nz   = (rem_reg != '0);

endmodule

// ----- sv/lbss_dp.sv -----
// ---------------------------------------------------------------------------
// lbss_dp
// Splitter datapath: configuration, stream counters, part threshold and
// the result register.
// ---------------------------------------------------------------------------
module lbss_dp
    import lbss_pkg::*;
#(
    parameter int BW = DEF_BYTE_WIDTH,
    parameter int LW = DEF_LINE_WIDTH,
    parameter int PW = DEF_PART_WIDTH,
    localparam int OUT_BITS = 8 + PW + 3 * LW + 3 * BW + 2,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [BW-1:0]         cfg_wdata,
    input  logic [7:0]            s_tdata,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [OUT_W-1:0]      m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast,
    input  cmd_t                  cmd,
    output sts_t                  sts
);

    // configuration
    logic [BW-1:0] total_reg;
    logic [PW-1:0] parts_reg;

    // stream state
    logic [BW-1:0] stream_offset_reg;
    logic [BW-1:0] bytes_in_part_reg;
    logic [BW-1:0] cut_threshold_reg;
    logic          thr_unlim_reg;
    logic [PW-1:0] current_part_reg;
    logic [LW-1:0] part_start_line_reg;
    logic [LW-1:0] lines_in_part_reg;
    logic [LW-1:0] line_number_reg;
    logic [BW-1:0] part_start_offset_reg;

    // result register
    logic          out_valid_reg;
    logic [1:0]    out_kind_reg;
    logic [7:0]    out_byte_reg;
    logic [PW-1:0] out_part_reg;
    logic [LW-1:0] out_first_line_reg;
    logic [LW-1:0] out_last_line_reg;
    logic [LW-1:0] out_line_total_reg;
    logic [BW-1:0] out_first_byte_reg;
    logic [BW:0]   out_last_byte_reg;
    logic [BW-1:0] out_part_bytes_reg;
    logic          out_len_ok_reg;
    logic          out_last_reg;

    logic          out_load;
    logic          slot_free;
    logic          is_lf;
    logic          cut;
    logic [PW-1:0] parts_eff;
    logic [PW-1:0] cp_next;
    logic          open_unlim;
    logic [PW-1:0] rp;
    logic [BW:0]   offset_diff;
    logic [BW-1:0] rem_bytes;
    logic [LW:0]   end_sum;
    logic [LW-1:0] rec_last_line;
    logic [LW-1:0] rec_line_total;
    logic [BW:0]   rec_last_byte;
    logic          len_ok;
    logic          div_start;
    logic          div_busy;
    logic          div_done;
    logic [BW-1:0] div_quo;
    logic          div_rem_nz;
    logic [OUT_BITS-1:0] packed_out;

    // cut decision for the incoming byte
    assign is_lf = (s_tdata == LINE_FEED);
    assign cut   = !thr_unlim_reg && (bytes_in_part_reg >= cut_threshold_reg) && is_lf;

    // part opening: number, last-part test, remaining parts and bytes
    assign parts_eff   = (parts_reg == '0) ? PW'(1) : parts_reg;
    assign cp_next     = (&current_part_reg) ? current_part_reg
                                             : current_part_reg + PW'(1);
    assign open_unlim  = (cp_next >= parts_eff) || (&cp_next);
    assign rp          = parts_eff - cp_next + PW'(1);
    assign offset_diff = {1'b0, total_reg} - {1'b0, stream_offset_reg};
    assign rem_bytes   = offset_diff[BW] ? '0 : offset_diff[BW-1:0];
    assign div_start   = cmd.open_part && !open_unlim;

    lbss_div #(
        .BW (BW),
        .PW (PW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rem_bytes),
        .divisor  (rp),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo),
        .rem_nz   (div_rem_nz)
    );

    // record fields, last line saturates at the counter maximum
    assign end_sum        = {1'b0, part_start_line_reg} + {1'b0, lines_in_part_reg - LW'(1)};
    assign rec_last_line  = (lines_in_part_reg == '0) ? part_start_line_reg
                          : (end_sum[LW] ? '1 : end_sum[LW-1:0]);
    assign rec_line_total = (lines_in_part_reg == '0) ? LW'(1)
                          : (end_sum[LW] ? (~part_start_line_reg + LW'(1))
                                         : lines_in_part_reg);
    assign rec_last_byte  = {1'b0, stream_offset_reg} - (BW + 1)'(1);
    assign len_ok         = (stream_offset_reg == total_reg);

    assign slot_free = !out_valid_reg || m_tready;
    assign out_load  = cmd.pass_byte || cmd.end_rec || cmd.idle_done
                    || cmd.cut_rec || cmd.done_emit;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            parts_reg <= PW'(DEFAULT_PARTS);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_TOTAL_BYTES: total_reg <= cfg_wdata;
                REG_PARTS_COUNT: parts_reg <= cfg_wdata[PW-1:0];
                default: ;
            endcase
        end
    end

    // stream counters and part state
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.start_stream) begin
            stream_offset_reg     <= '0;
            bytes_in_part_reg     <= '0;
            cut_threshold_reg     <= '0;
            thr_unlim_reg         <= 1'b0;
            current_part_reg      <= '0;
            part_start_line_reg   <= LW'(1);
            lines_in_part_reg     <= '0;
            line_number_reg       <= LW'(1);
            part_start_offset_reg <= '0;
        end else begin
            if (cmd.pass_byte) begin
                if (!(&stream_offset_reg)) begin
                    stream_offset_reg <= stream_offset_reg + BW'(1);
                end
                if (!(&bytes_in_part_reg)) begin
                    bytes_in_part_reg <= bytes_in_part_reg + BW'(1);
                end
                if (is_lf && !(&lines_in_part_reg)) begin
                    lines_in_part_reg <= lines_in_part_reg + LW'(1);
                end
                if (is_lf && !(&line_number_reg)) begin
                    line_number_reg <= line_number_reg + LW'(1);
                end
            end
            if (cmd.open_part) begin
                current_part_reg      <= cp_next;
                part_start_offset_reg <= stream_offset_reg;
                part_start_line_reg   <= line_number_reg;
                lines_in_part_reg     <= '0;
                bytes_in_part_reg     <= '0;
                thr_unlim_reg         <= open_unlim;
                if (open_unlim) begin
                    cut_threshold_reg <= '0;
                end
            end
            if (cmd.thr_load) begin
                cut_threshold_reg <= div_quo + BW'(div_rem_nz);
            end
            if (cmd.done_emit) begin
                current_part_reg <= '0;
            end
        end
    end

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_byte_reg       <= '0;
            out_part_reg       <= current_part_reg;
            out_first_line_reg <= '0;
            out_last_line_reg  <= '0;
            out_line_total_reg <= '0;
            out_first_byte_reg <= '0;
            out_last_byte_reg  <= '0;
            out_part_bytes_reg <= '0;
            out_len_ok_reg     <= 1'b0;
            out_last_reg       <= 1'b1;
            if (cmd.pass_byte) begin
                out_kind_reg <= KIND_BYTE;
                out_byte_reg <= s_tdata;
                out_last_reg <= !cut;
            end else if (cmd.cut_rec || cmd.end_rec) begin
                out_kind_reg       <= KIND_RECORD;
                out_first_line_reg <= part_start_line_reg;
                out_last_line_reg  <= rec_last_line;
                out_line_total_reg <= rec_line_total;
                out_first_byte_reg <= part_start_offset_reg;
                out_last_byte_reg  <= rec_last_byte;
                out_part_bytes_reg <= bytes_in_part_reg;
                out_last_reg       <= cmd.cut_rec;
            end else begin
                out_kind_reg   <= KIND_DONE;
                out_len_ok_reg <= cmd.done_emit && len_ok;
                if (cmd.idle_done) begin
                    out_part_reg <= '0;
                end
            end
        end
    end

    // pack result fields, lowest first
    assign packed_out = {out_len_ok_reg, out_part_bytes_reg, out_last_byte_reg,
                         out_first_byte_reg, out_line_total_reg, out_last_line_reg,
                         out_first_line_reg, out_part_reg, out_byte_reg};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(packed_out);
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // status to controller
    assign sts.part_open  = (current_part_reg != '0);
    assign sts.cut        = cut;
    assign sts.slot_free  = slot_free;
    assign sts.open_unlim = open_unlim;
    assign sts.div_done   = div_done;
    assign sts.div_busy   = div_busy;

endmodule

// ----- sv/lbss_ctrl.sv -----
// ---------------------------------------------------------------------------
// lbss_ctrl
// Splitter controller: input acceptance and result sequencing.
// ---------------------------------------------------------------------------
module lbss_ctrl
    import lbss_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic [1:0] s_req,
    output logic       s_tready,
    input  sts_t       sts,
    output cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_REC  = 3'd1;
    localparam logic [2:0] ST_OPEN = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE) && sts.slot_free;
    assign accept   = s_tvalid && s_tready;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_req)
                        REQ_START: begin
                            cmd.start_stream = 1'b1;
                            state_next       = ST_OPEN;
                        end
                        REQ_DATA: begin
                            if (sts.part_open) begin
                                cmd.pass_byte = 1'b1;
                                if (sts.cut) begin
                                    state_next = ST_REC;
                                end
                            end
                        end
                        REQ_END: begin
                            if (sts.part_open) begin
                                cmd.end_rec = 1'b1;
                                state_next  = ST_DONE;
                            end else begin
                                cmd.idle_done = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_REC: begin
                if (sts.slot_free) begin
                    cmd.cut_rec = 1'b1;
                    state_next  = ST_OPEN;
                end
            end
            ST_OPEN: begin
                cmd.open_part = 1'b1;
                state_next    = sts.open_unlim ? ST_IDLE : ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    cmd.thr_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DONE: begin
                if (sts.slot_free) begin
                    cmd.done_emit = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/line_aligned_balanced_stream_splitter.sv -----
// ---------------------------------------------------------------------------
// line_aligned_balanced_stream_splitter
// Splits a text byte stream into balanced, line-aligned parts.
// ---------------------------------------------------------------------------
// A start transaction opens part 1, data transactions pass bytes through
// tagged with their part while one is open, and an end transaction closes
// the stream with a part record if a part is open, and a done status. A
// data byte is taken in idle when the result register is free. A byte that
// cuts a part gives its byte, then its record result; the next part is
// opened and, unless it is the last, the radix-2 divider forms the cut
// threshold; a start transaction costs the same open sequence. An end
// transaction with an open stream gives a record, then a done status. The
// result register holds one result; input stalls if it is full and untaken.
`include "line_aligned_balanced_stream_splitter_defines.svh"

module line_aligned_balanced_stream_splitter
    import lbss_pkg::*;
#(
    parameter int BYTE_WIDTH = DEF_BYTE_WIDTH,
    parameter int LINE_WIDTH = DEF_LINE_WIDTH,
    parameter int PART_WIDTH = DEF_PART_WIDTH,
    localparam int OUT_BITS = 8 + PART_WIDTH + 3 * LINE_WIDTH + 3 * BYTE_WIDTH + 2,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [BYTE_WIDTH-1:0] cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // data_byte
    input  logic [1:0]            s_tuser,   // req_type
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // out_byte, part_index, first_line,
                                             // last_line, line_total, first_byte,
                                             // last_byte, part_bytes, length_ok
    output logic [1:0]            m_tuser,   // result_kind
    output logic                  m_tlast
);

    cmd_t cmd;
    sts_t sts;

    lbss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_req    (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lbss_dp #(
        .BW (BYTE_WIDTH),
        .LW (LINE_WIDTH),
        .PW (PART_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

    // checks
    `LBSS_ASSERT_NOW(a_no_take_while_div, aclk, aresetn, sts.div_busy, !s_tready,
        "input taken while divider busy")
    `LBSS_ASSERT_NOW(a_take_needs_slot, aclk, aresetn, s_tready, (!m_tvalid || m_tready),
        "input taken with result register full")
    `LBSS_ASSERT_NEXT(a_cut_then_record, aclk, aresetn,
        (m_tvalid && m_tready && (m_tuser == KIND_BYTE) && !m_tlast),
        (m_tvalid && (m_tuser == KIND_RECORD) && m_tlast),
        "cut byte not followed by record")
    `LBSS_ASSERT_NEXT(a_end_then_done, aclk, aresetn,
        (m_tvalid && m_tready && (m_tuser == KIND_RECORD) && !m_tlast),
        (m_tvalid && (m_tuser == KIND_DONE) && m_tlast),
        "end record not followed by done status")

endmodule
